// ===== design/ipv4tcp_pkg.sv =====
package ipv4tcp_pkg;

    // field positions in the ipv4 header
    localparam logic [15:0] POS_VER_IHL   = 16'd0;
    localparam logic [15:0] POS_LEN_HI    = 16'd2;
    localparam logic [15:0] POS_LEN_LO    = 16'd3;
    localparam logic [15:0] POS_PROTO     = 16'd9;
    localparam logic [15:0] POS_SRC_FIRST = 16'd12;
    localparam logic [15:0] POS_SRC_LAST  = 16'd15;
    localparam logic [15:0] POS_DST_FIRST = 16'd16;
    localparam logic [15:0] POS_DST_LAST  = 16'd19;

    // field positions in the tcp header, relative to its start
    localparam logic [15:0] TCP_SPORT_LAST = 16'd1;
    localparam logic [15:0] TCP_DPORT_LAST = 16'd3;
    localparam logic [15:0] TCP_SEQ_LAST   = 16'd7;
    localparam logic [15:0] TCP_ACK_LAST   = 16'd11;
    localparam logic [15:0] TCP_OFFSET     = 16'd12;
    localparam logic [15:0] TCP_FLAGS      = 16'd13;

    // saturation point of the byte count
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // validity checks
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [3:0]  MIN_WORDS     = 4'd5;

    // per-packet capture state, also the record handed to the checker
    typedef struct packed {
        logic [15:0] byte_count;
        logic [7:0]  first_byte;
        logic [7:0]  protocol;
        logic [15:0] ip_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] tcp_sport;
        logic [15:0] tcp_dport;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [3:0]  offset_words;
        logic [7:0]  flags;
    } t_pkt_rec;

    // one result beat
    typedef struct packed {
        logic        valid_res;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] sequence_number;
        logic [31:0] ack_number;
        logic [7:0]  flag_bits;
        logic [15:0] payload_length;
    } t_result;

endpackage

// ===== design/ipv4tcp_capture.sv =====
module ipv4tcp_capture (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    output ipv4tcp_pkg::t_pkt_rec o_rec,
    output logic                  o_rec_vld,
    input  logic                  i_rec_take
);

    ipv4tcp_pkg::t_pkt_rec r_st;
    ipv4tcp_pkg::t_pkt_rec n_st;
    ipv4tcp_pkg::t_pkt_rec r_rec;
    logic                  r_rec_vld;

    logic [15:0] byte_pos;
    logic [5:0]  tcp_base;
    logic [15:0] tcp_rel;
    logic        beat;

    // a last byte needs the record slot, so hold off only while it is full
    assign o_stall   = r_rec_vld && !i_rec_take;
    assign beat      = i_valid && !o_stall;
    assign o_rec     = r_rec;
    assign o_rec_vld = r_rec_vld;

    // the ihl of the current byte counts when it is the version/ihl byte itself
    assign byte_pos = r_st.byte_count;
    assign tcp_base = (byte_pos == ipv4tcp_pkg::POS_VER_IHL) ?
                      {i_data_byte[3:0], 2'b00} : {r_st.first_byte[3:0], 2'b00};
    assign tcp_rel  = byte_pos - {10'd0, tcp_base};

    // field capture for the current byte
    always_comb begin
        n_st = r_st;
        if (byte_pos == ipv4tcp_pkg::POS_VER_IHL) begin
            n_st.first_byte = i_data_byte;
        end else if (byte_pos == ipv4tcp_pkg::POS_LEN_HI ||
                     byte_pos == ipv4tcp_pkg::POS_LEN_LO) begin
            n_st.ip_length = {r_st.ip_length[7:0], i_data_byte};
        end else if (byte_pos == ipv4tcp_pkg::POS_PROTO) begin
            n_st.protocol = i_data_byte;
        end else if (byte_pos >= ipv4tcp_pkg::POS_SRC_FIRST &&
                     byte_pos <= ipv4tcp_pkg::POS_SRC_LAST) begin
            n_st.src_addr = {r_st.src_addr[23:0], i_data_byte};
        end else if (byte_pos >= ipv4tcp_pkg::POS_DST_FIRST &&
                     byte_pos <= ipv4tcp_pkg::POS_DST_LAST) begin
            n_st.dst_addr = {r_st.dst_addr[23:0], i_data_byte};
        end

        // tcp fields sit after the ip header, located by the ihl
        if (byte_pos >= {10'd0, tcp_base}) begin
            if (tcp_rel <= ipv4tcp_pkg::TCP_SPORT_LAST) begin
                n_st.tcp_sport = {r_st.tcp_sport[7:0], i_data_byte};
            end else if (tcp_rel <= ipv4tcp_pkg::TCP_DPORT_LAST) begin
                n_st.tcp_dport = {r_st.tcp_dport[7:0], i_data_byte};
            end else if (tcp_rel <= ipv4tcp_pkg::TCP_SEQ_LAST) begin
                n_st.seq_num = {r_st.seq_num[23:0], i_data_byte};
            end else if (tcp_rel <= ipv4tcp_pkg::TCP_ACK_LAST) begin
                n_st.ack_num = {r_st.ack_num[23:0], i_data_byte};
            end else if (tcp_rel == ipv4tcp_pkg::TCP_OFFSET) begin
                n_st.offset_words = i_data_byte[7:4];
            end else if (tcp_rel == ipv4tcp_pkg::TCP_FLAGS) begin
                n_st.flags = i_data_byte;
            end
        end

        // saturating byte count
        if (byte_pos == ipv4tcp_pkg::COUNT_MAX) begin
            n_st.byte_count = byte_pos;
        end else begin
            n_st.byte_count = byte_pos + 16'd1;
        end
    end

    // state update, record hand-over on the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= '0;
            r_rec     <= '0;
            r_rec_vld <= 1'b0;
        end else begin
            if (i_rec_take) begin
                r_rec_vld <= 1'b0;
            end
            if (beat) begin
                if (i_last_byte) begin
                    r_rec     <= n_st;
                    r_rec_vld <= 1'b1;
                    r_st      <= '0;
                end else begin
                    r_st <= n_st;
                end
            end
        end
    end

endmodule

// ===== design/ipv4tcp_check.sv =====
module ipv4tcp_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipv4tcp_pkg::t_pkt_rec i_rec,
    input  logic                  i_rec_vld,
    output logic                  o_rec_take,
    output ipv4tcp_pkg::t_result  o_res,
    output logic                  o_valid,
    input  logic                  i_stall
);

    ipv4tcp_pkg::t_result r_res;
    ipv4tcp_pkg::t_result n_res;
    logic                 r_out_vld;

    logic [3:0]  ihl;
    logic [15:0] ip_len;
    logic [15:0] tcp_len;
    logic [15:0] tcp_avail;
    logic        ip_ok;
    logic        pkt_ok;
    logic        out_ready;

    assign out_ready  = !r_out_vld || !i_stall;
    assign o_rec_take = i_rec_vld && out_ready;
    assign o_res      = r_res;
    assign o_valid    = r_out_vld;

    assign ihl       = i_rec.first_byte[3:0];
    assign ip_len    = {10'd0, ihl, 2'b00};
    assign tcp_len   = {10'd0, i_rec.offset_words, 2'b00};
    assign tcp_avail = i_rec.ip_length - ip_len;

    // ip header and length checks
    assign ip_ok = i_rec.byte_count >= ipv4tcp_pkg::MIN_HDR_BYTES
        && i_rec.first_byte[7:4] == ipv4tcp_pkg::IP_VERSION
        && ihl >= ipv4tcp_pkg::MIN_WORDS
        && i_rec.byte_count >= ip_len
        && i_rec.protocol == ipv4tcp_pkg::PROTO_TCP
        && i_rec.ip_length >= ip_len + ipv4tcp_pkg::MIN_HDR_BYTES
        && i_rec.byte_count >= i_rec.ip_length;

    // tcp header checks
    assign pkt_ok = ip_ok
        && i_rec.offset_words >= ipv4tcp_pkg::MIN_WORDS
        && tcp_avail >= tcp_len;

    // result fields, all zero for a rejected packet
    always_comb begin
        n_res = '0;
        if (pkt_ok) begin
            n_res.valid_res       = 1'b1;
            n_res.source_address  = i_rec.src_addr;
            n_res.dest_address    = i_rec.dst_addr;
            n_res.source_port     = i_rec.tcp_sport;
            n_res.dest_port       = i_rec.tcp_dport;
            n_res.sequence_number = i_rec.seq_num;
            n_res.ack_number      = i_rec.ack_num;
            n_res.flag_bits       = i_rec.flags;
            n_res.payload_length  = tcp_avail - tcp_len;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_res     <= '0;
        end else begin
            if (out_ready) begin
                r_out_vld <= i_rec_vld;
            end
            if (o_rec_take) begin
                r_res <= n_res;
            end
        end
    end

endmodule

// ===== design/ipv4_tcp_header_parser_core.sv =====
// IPv4/TCP header parser. Packet bytes enter one per beat, starting at IPv4
// header byte zero, with i_last_byte marking the final byte; one byte is taken
// every cycle while o_stall is low. Each byte updates the field capture
// registers, and the last byte moves the captured fields into a record
// register and clears the capture state, so the next packet may follow in the
// very next cycle. The record is checked combinationally and the result is
// registered when the result register is free or not stalled; o_valid rises
// when it is loaded. Input is stalled only when a finished record cannot move
// on because the result register is full and stalled. A rejected packet
// reports o_valid_res low with every other field zero.
module ipv4_tcp_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [31:0] o_source_address,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [31:0] o_sequence_number,
    output logic [31:0] o_ack_number,
    output logic [7:0]  o_flag_bits,
    output logic [15:0] o_payload_length
);

    ipv4tcp_pkg::t_pkt_rec rec;
    logic                  rec_vld;
    logic                  rec_take;
    ipv4tcp_pkg::t_result  res;

    // byte capture
    ipv4tcp_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_rec       (rec),
        .o_rec_vld   (rec_vld),
        .i_rec_take  (rec_take)
    );

    // packet checks and result register
    ipv4tcp_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (rec),
        .i_rec_vld  (rec_vld),
        .o_rec_take (rec_take),
        .o_res      (res),
        .o_valid    (o_valid),
        .i_stall    (i_stall)
    );

    assign o_valid_res       = res.valid_res;
    assign o_source_address  = res.source_address;
    assign o_dest_address    = res.dest_address;
    assign o_source_port     = res.source_port;
    assign o_dest_port       = res.dest_port;
    assign o_sequence_number = res.sequence_number;
    assign o_ack_number      = res.ack_number;
    assign o_flag_bits       = res.flag_bits;
    assign o_payload_length  = res.payload_length;

endmodule
